// ===== src/pbgp_pkg.sv =====
// shared types and constants of the paddle and button game port
package pbgp_pkg;

    localparam int CYCLE_BITS   = 48;
    localparam int NUM_BUTTONS  = 3;
    localparam int NUM_AXES     = 4;
    localparam int HOLD_W       = 16;
    localparam int POS_W        = 8;
    localparam int PROD_W       = 24;
    localparam int QUOT_W       = 17;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    localparam int IN_FIELD_BITS = 28 + CYCLE_BITS;
    localparam int IN_DATA_W     = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OFS_ADDR      = 0;
    localparam int OFS_CYCLE     = 8;
    localparam int OFS_BIDX      = OFS_CYCLE + CYCLE_BITS;
    localparam int OFS_DOWN      = OFS_BIDX + 2;
    localparam int OFS_STICK     = OFS_DOWN + 1;
    localparam int OFS_XPOS      = OFS_STICK + 1;
    localparam int OFS_YPOS      = OFS_XPOS + POS_W;
    localparam int OUT_DATA_W    = 8;

    localparam logic [7:0]        ADDR_BUTTON0 = 8'h61;
    localparam logic [7:0]        ADDR_BUTTON2 = 8'h63;
    localparam logic [5:0]        ADDR_PADDLE  = 6'b011001;
    localparam logic [3:0]        ADDR_TSTART  = 4'h7;
    localparam logic [POS_W-1:0]  AXIS_CENTER  = 8'd127;
    localparam logic [HOLD_W-1:0] LATCH_RESET  = 16'd5000;
    localparam logic [HOLD_W-1:0] SPAN_RESET   = 16'd2816;
    localparam logic [PROD_W:0]   SPAN_DIV     = 25'd255;
    localparam logic [PROD_W:0]   SPAN_DIV2    = 25'd510;

    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PADDLE_SPAN = 1'b1;

    typedef enum logic [1:0] {
        KIND_READ     = 2'd0,
        KIND_TICK     = 2'd1,
        KIND_BUTTON   = 2'd2,
        KIND_POSITION = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [7:0]            address;
        logic [CYCLE_BITS-1:0] cycle_now;
        logic [1:0]            button_index;
        logic                  pressed;
        logic                  stick;
        logic [POS_W-1:0]      x_pos;
        logic [POS_W-1:0]      y_pos;
    } t_item;

    typedef struct packed {
        logic                  paddle;
        logic                  value;
        logic                  driven;
        logic                  ts_ahead;
        logic [CYCLE_BITS-1:0] elapsed;
        logic [PROD_W-1:0]     delay_num;
    } t_mid;

endpackage

// ===== src/pbgp_state.sv =====
// button latches, axis positions and timer start updated per request, config registers by config writes
module pbgp_state (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pbgp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pbgp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  pbgp_pkg::t_item                    i_item,
    input  logic                               i_fire,
    output logic                               o_has_result,
    output pbgp_pkg::t_mid                     o_mid
);

    logic [pbgp_pkg::HOLD_W-1:0]     r_latch_ticks;
    logic [pbgp_pkg::HOLD_W-1:0]     r_paddle_span;
    logic [pbgp_pkg::HOLD_W-1:0]     r_hold  [pbgp_pkg::NUM_BUTTONS];
    logic [pbgp_pkg::HOLD_W-1:0]     n_hold  [pbgp_pkg::NUM_BUTTONS];
    logic                            r_level [pbgp_pkg::NUM_BUTTONS];
    logic                            n_level [pbgp_pkg::NUM_BUTTONS];
    logic [pbgp_pkg::POS_W-1:0]      r_axis  [pbgp_pkg::NUM_AXES];
    logic [pbgp_pkg::POS_W-1:0]      n_axis  [pbgp_pkg::NUM_AXES];
    logic [pbgp_pkg::CYCLE_BITS-1:0] r_tstart;
    logic [pbgp_pkg::CYCLE_BITS-1:0] n_tstart;

    logic       is_button_addr;
    logic       is_paddle_addr;
    logic       is_tstart_addr;
    logic [1:0] read_button;
    logic [pbgp_pkg::POS_W-1:0]      sel_pos;
    logic [pbgp_pkg::CYCLE_BITS:0]   diff;

    assign is_button_addr = (i_item.address >= pbgp_pkg::ADDR_BUTTON0) &&
                            (i_item.address <= pbgp_pkg::ADDR_BUTTON2);
    assign is_paddle_addr = (i_item.address[7:2] == pbgp_pkg::ADDR_PADDLE);
    assign is_tstart_addr = (i_item.address[7:4] == pbgp_pkg::ADDR_TSTART);
    assign read_button    = 2'(i_item.address - pbgp_pkg::ADDR_BUTTON0);
    assign sel_pos        = r_axis[i_item.address[1:0]];
    assign diff           = {1'b0, i_item.cycle_now} - {1'b0, r_tstart};

    always_comb begin
        o_has_result       = 1'b0;
        o_mid.paddle       = 1'b0;
        o_mid.value        = 1'b0;
        o_mid.driven       = 1'b0;
        o_mid.ts_ahead     = diff[pbgp_pkg::CYCLE_BITS];
        o_mid.elapsed      = diff[pbgp_pkg::CYCLE_BITS-1:0];
        o_mid.delay_num    = pbgp_pkg::PROD_W'(sel_pos) * pbgp_pkg::PROD_W'(r_paddle_span);
        n_hold             = r_hold;
        n_level            = r_level;
        n_axis             = r_axis;
        n_tstart           = r_tstart;
        case (i_item.kind)
            pbgp_pkg::KIND_TICK: begin
                for (int i = 0; i < pbgp_pkg::NUM_BUTTONS; i++) begin
                    if (r_hold[i] != '0) begin
                        n_hold[i] = r_hold[i] - 1'b1;
                    end
                end
            end
            pbgp_pkg::KIND_BUTTON: begin
                if (i_item.button_index < 2'(pbgp_pkg::NUM_BUTTONS)) begin
                    if (i_item.pressed && !r_level[i_item.button_index]) begin
                        n_hold[i_item.button_index] = r_latch_ticks;
                    end
                    n_level[i_item.button_index] = i_item.pressed;
                end
            end
            pbgp_pkg::KIND_POSITION: begin
                n_axis[{i_item.stick, 1'b0}] = i_item.x_pos;
                n_axis[{i_item.stick, 1'b1}] = i_item.y_pos;
            end
            pbgp_pkg::KIND_READ: begin
                if (is_button_addr) begin
                    o_has_result        = 1'b1;
                    o_mid.value         = (r_hold[read_button] != '0) || r_level[read_button];
                    o_mid.driven        = 1'b1;
                    n_hold[read_button] = '0;
                end else if (is_paddle_addr) begin
                    o_has_result = 1'b1;
                    o_mid.paddle = 1'b1;
                    o_mid.driven = 1'b1;
                end else if (is_tstart_addr) begin
                    o_has_result = 1'b1;
                    n_tstart     = i_item.cycle_now;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch_ticks <= pbgp_pkg::LATCH_RESET;
            r_paddle_span <= pbgp_pkg::SPAN_RESET;
            r_tstart      <= '0;
            for (int i = 0; i < pbgp_pkg::NUM_BUTTONS; i++) begin
                r_hold[i]  <= '0;
                r_level[i] <= 1'b0;
            end
            for (int i = 0; i < pbgp_pkg::NUM_AXES; i++) begin
                r_axis[i] <= pbgp_pkg::AXIS_CENTER;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pbgp_pkg::CFG_LATCH_TICKS: r_latch_ticks <= i_cfg_data;
                    pbgp_pkg::CFG_PADDLE_SPAN: r_paddle_span <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_fire) begin
                r_hold   <= n_hold;
                r_level  <= n_level;
                r_axis   <= n_axis;
                r_tstart <= n_tstart;
            end
        end
    end

endmodule

// ===== src/pbgp_timer_cmp.sv =====
// paddle timer check: delay = product / 255, then elapsed cycles against delay; other results pass their value through
module pbgp_timer_cmp (
    input  pbgp_pkg::t_mid i_mid,
    output logic           o_value,
    output logic           o_driven
);

    logic [pbgp_pkg::PROD_W+8:0]   scaled;
    logic [pbgp_pkg::QUOT_W-1:0]   q0;
    logic [pbgp_pkg::PROD_W:0]     q0_x255;
    logic [pbgp_pkg::PROD_W:0]     rem;
    logic [pbgp_pkg::QUOT_W-1:0]   quot;
    logic                          in_window;

    // x / 255 ~ x * 257 / 65536, then at most two corrections
    assign scaled  = {9'b0, i_mid.delay_num} + {1'b0, i_mid.delay_num, 8'b0};
    assign q0      = scaled[pbgp_pkg::PROD_W+8:16];
    assign q0_x255 = {q0, 8'b0} - {8'b0, q0};
    assign rem     = {1'b0, i_mid.delay_num} - q0_x255;

    always_comb begin
        if (rem >= pbgp_pkg::SPAN_DIV2) begin
            quot = q0 + 2'd2;
        end else if (rem >= pbgp_pkg::SPAN_DIV) begin
            quot = q0 + 1'b1;
        end else begin
            quot = q0;
        end
    end

    assign in_window = (i_mid.elapsed[pbgp_pkg::CYCLE_BITS-1:pbgp_pkg::PROD_W] == '0) &&
                       (i_mid.elapsed[pbgp_pkg::PROD_W-1:0] <= pbgp_pkg::PROD_W'(quot));

    assign o_value  = i_mid.paddle ? (i_mid.ts_ahead || in_window) : i_mid.value;
    assign o_driven = i_mid.driven;

endmodule

// ===== src/paddle_button_game_port_unit.sv =====
// top level of the paddle and button game port
//
// one request per input beat: tuser carries the kind (bus read, tick, button
// event, position event), tdata the remaining fields. bus reads of a button,
// paddle or timer start address give one result beat; all other requests
// only update state. result tdata bit 0 is status bit seven, tuser bit 0 says
// whether that bit is driven or floating.
// a request is taken every cycle while s_axis_tready is high. a request passes
// the input register, then state update with the paddle product and
// elapsed-cycle subtract into the middle register, then divide by 255 and
// compare into the result register.
// when the receiver stalls, the result register holds and the middle and
// input registers fill behind it; s_axis_tready drops once all three are
// full and the input request gives a result, so up to three requests are held.
// reset clears all pipeline valids, button latches and levels and the timer
// start, centers all paddles and loads default hold ticks and paddle span.
// config writes are taken at any edge and must only come while idle.
module paddle_button_game_port_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pbgp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pbgp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // address, cycle_now, button_index, pressed, stick, x_pos, y_pos, zero pad
    input  logic [pbgp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // kind
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // bit_value, zero pad
    output logic [pbgp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // bit_driven
    output logic                                m_axis_tuser
);

    pbgp_pkg::t_item in_item;
    pbgp_pkg::t_item r_in;
    logic            r_in_v;
    pbgp_pkg::t_mid  mid;
    pbgp_pkg::t_mid  r_mid;
    logic            r_mid_v;
    logic            r_out_v;
    logic            r_out_value;
    logic            r_out_driven;
    logic            has_result;
    logic            cmp_value;
    logic            cmp_driven;
    logic            fire_a;
    logic            fire_b;

    assign in_item.kind         = pbgp_pkg::t_kind'(s_axis_tuser);
    assign in_item.address      = s_axis_tdata[pbgp_pkg::OFS_ADDR +: 8];
    assign in_item.cycle_now    = s_axis_tdata[pbgp_pkg::OFS_CYCLE +: pbgp_pkg::CYCLE_BITS];
    assign in_item.button_index = s_axis_tdata[pbgp_pkg::OFS_BIDX +: 2];
    assign in_item.pressed      = s_axis_tdata[pbgp_pkg::OFS_DOWN];
    assign in_item.stick        = s_axis_tdata[pbgp_pkg::OFS_STICK];
    assign in_item.x_pos        = s_axis_tdata[pbgp_pkg::OFS_XPOS +: pbgp_pkg::POS_W];
    assign in_item.y_pos        = s_axis_tdata[pbgp_pkg::OFS_YPOS +: pbgp_pkg::POS_W];

    assign fire_b        = r_mid_v && (!r_out_v || m_axis_tready);
    assign fire_a        = r_in_v && (!has_result || !r_mid_v || fire_b);
    assign s_axis_tready = !r_in_v || fire_a;

    pbgp_state u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item       (r_in),
        .i_fire       (fire_a),
        .o_has_result (has_result),
        .o_mid        (mid)
    );

    pbgp_timer_cmp u_timer_cmp (
        .i_mid    (r_mid),
        .o_value  (cmp_value),
        .o_driven (cmp_driven)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_mid_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_v <= 1'b1;
            end else if (fire_a) begin
                r_in_v <= 1'b0;
            end
            if (fire_a && has_result) begin
                r_mid_v <= 1'b1;
            end else if (fire_b) begin
                r_mid_v <= 1'b0;
            end
            if (fire_b) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= in_item;
        end
        if (fire_a && has_result) begin
            r_mid <= mid;
        end
        if (fire_b) begin
            r_out_value  <= cmp_value;
            r_out_driven <= cmp_driven;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {(pbgp_pkg::OUT_DATA_W - 1)'(0), r_out_value};
    assign m_axis_tuser  = r_out_driven;

endmodule

// ===== tb/paddle_button_game_port_unit_tb.sv =====
// testbench of the game port: directed and random requests checked against a behavioral port model
module paddle_button_game_port_unit_tb;
    import pbgp_pkg::*;

    typedef struct packed {
        logic value;
        logic driven;
    } t_bit7;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // address, cycle_now, button_index, pressed, stick, x_pos, y_pos, zero pad
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    // kind
    logic [1:0]             s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // bit_value, zero pad
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    // bit_driven
    logic                   m_axis_tuser;

    logic [HOLD_W-1:0]      model_latch;
    logic [HOLD_W-1:0]      model_span;
    logic [HOLD_W-1:0]      model_hold [NUM_BUTTONS];
    logic                   model_level [NUM_BUTTONS];
    logic [POS_W-1:0]       model_axis [NUM_AXES];
    logic [CYCLE_BITS-1:0]  model_tstart;

    t_bit7                  bit7_queue [$];
    int                     fail_count = 0;
    bit                     steady = 1'b0;
    logic [CYCLE_BITS-1:0]  cycle_cursor;

    paddle_button_game_port_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic logic [CYCLE_BITS-1:0] paddle_delay(input logic [1:0] sel);
        return CYCLE_BITS'((64'(model_axis[sel]) * 64'(model_span)) / 64'd255);
    endfunction

    function automatic t_item filler();
        t_item it;
        it.kind         = t_kind'($urandom_range(0, 3));
        it.address      = 8'($urandom);
        it.cycle_now    = CYCLE_BITS'({$urandom, $urandom});
        it.button_index = 2'($urandom);
        it.pressed      = 1'($urandom);
        it.stick        = 1'($urandom);
        it.x_pos        = 8'($urandom);
        it.y_pos        = 8'($urandom);
        return it;
    endfunction

    task automatic advance_port_model(input t_item it);
        int    b;
        t_bit7 r;
        case (it.kind)
            KIND_TICK: begin
                for (b = 0; b < NUM_BUTTONS; b++)
                    if (model_hold[b] != '0) model_hold[b] = model_hold[b] - 1'b1;
            end
            KIND_BUTTON: begin
                if (it.button_index < NUM_BUTTONS) begin
                    if (it.pressed && !model_level[it.button_index])
                        model_hold[it.button_index] = model_latch;
                    model_level[it.button_index] = it.pressed;
                end
            end
            KIND_POSITION: begin
                model_axis[{it.stick, 1'b0}] = it.x_pos;
                model_axis[{it.stick, 1'b1}] = it.y_pos;
            end
            default: begin
                if (it.address >= ADDR_BUTTON0 && it.address <= ADDR_BUTTON2) begin
                    b = it.address - ADDR_BUTTON0;
                    r.value  = (model_hold[b] != '0) || model_level[b];
                    r.driven = 1'b1;
                    model_hold[b] = '0;
                    bit7_queue.push_back(r);
                end else if (it.address[7:2] == ADDR_PADDLE) begin
                    r.value  = (it.cycle_now < model_tstart) ||
                               ((it.cycle_now - model_tstart) <= paddle_delay(it.address[1:0]));
                    r.driven = 1'b1;
                    bit7_queue.push_back(r);
                end else if (it.address[7:4] == ADDR_TSTART) begin
                    model_tstart = it.cycle_now;
                    r.value  = 1'b0;
                    r.driven = 1'b0;
                    bit7_queue.push_back(r);
                end
            end
        endcase
    endtask

    task automatic send_request(input t_item it);
        int                   gap;
        logic [IN_DATA_W-1:0] beat;
        gap = draw_wait();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        beat = '0;
        beat[OFS_ADDR  +: 8]          = it.address;
        beat[OFS_CYCLE +: CYCLE_BITS] = it.cycle_now;
        beat[OFS_BIDX  +: 2]          = it.button_index;
        beat[OFS_DOWN]                = it.pressed;
        beat[OFS_STICK]               = it.stick;
        beat[OFS_XPOS  +: POS_W]      = it.x_pos;
        beat[OFS_YPOS  +: POS_W]      = it.y_pos;
        s_axis_tdata  <= beat;
        s_axis_tuser  <= it.kind;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_port_model(it);
    endtask

    task automatic read_at(input logic [7:0] addr, input logic [CYCLE_BITS-1:0] cyc);
        t_item it;
        it = filler();
        it.kind      = KIND_READ;
        it.address   = addr;
        it.cycle_now = cyc;
        send_request(it);
    endtask

    task automatic tick_once();
        t_item it;
        it = filler();
        it.kind = KIND_TICK;
        send_request(it);
    endtask

    task automatic button_event(input logic [1:0] idx, input logic down);
        t_item it;
        it = filler();
        it.kind         = KIND_BUTTON;
        it.button_index = idx;
        it.pressed      = down;
        send_request(it);
    endtask

    task automatic position_event(input logic stick, input logic [7:0] x, input logic [7:0] y);
        t_item it;
        it = filler();
        it.kind  = KIND_POSITION;
        it.stick = stick;
        it.x_pos = x;
        it.y_pos = y;
        send_request(it);
    endtask

    // drop valid and let every pending result and trailing request drain
    task automatic settle_port();
        s_axis_tvalid <= 1'b0;
        while (bit7_queue.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [HOLD_W-1:0] latch, input logic [HOLD_W-1:0] span);
        settle_port();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LATCH_TICKS;
        i_cfg_data  <= latch;
        @(posedge i_clk);
        i_cfg_index <= CFG_PADDLE_SPAN;
        i_cfg_data  <= span;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        model_latch = latch;
        model_span  = span;
    endtask

    task automatic test_directed_basics();
        read_at(ADDR_BUTTON0, '0);
        read_at(ADDR_BUTTON2, '0);
        read_at({ADDR_PADDLE, 2'd0}, '0);
        read_at({ADDR_TSTART, 4'h0}, 48'd1000);
        read_at({ADDR_PADDLE, 2'd1}, 48'd2402);
        read_at({ADDR_PADDLE, 2'd2}, 48'd2403);
        read_at({ADDR_PADDLE, 2'd3}, 48'd999);
        // unmapped reads
        read_at(8'h00, '0);
        read_at(8'hFF, '0);
        read_at(ADDR_BUTTON0 - 8'd1, '0);
        read_at({ADDR_PADDLE, 2'd3} + 8'd1, '0);
        button_event(2'd3, 1'b1);
        button_event(2'd0, 1'b1);
        button_event(2'd0, 1'b1);
        button_event(2'd0, 1'b0);
        tick_once();
        read_at(ADDR_BUTTON0, '0);
        read_at(ADDR_BUTTON0, '0);
        position_event(1'b0, 8'd0, 8'd255);
        position_event(1'b1, 8'd255, 8'd0);
        read_at({ADDR_TSTART, 4'hF}, {CYCLE_BITS{1'b1}});
        read_at({ADDR_PADDLE, 2'd0}, {CYCLE_BITS{1'b1}});
        read_at({ADDR_PADDLE, 2'd1}, '0);
        button_event(2'd2, 1'b1);
        read_at(ADDR_BUTTON2, '0);
        button_event(2'd1, 1'b1);
        button_event(2'd1, 1'b0);
        read_at(ADDR_BUTTON0 + 8'd1, '0);
    endtask

    task automatic test_register_extremes();
        set_config('0, '0);
        button_event(2'd1, 1'b1);
        button_event(2'd1, 1'b0);
        read_at(ADDR_BUTTON0 + 8'd1, '0);
        read_at({ADDR_TSTART, 4'h3}, 48'd100);
        read_at({ADDR_PADDLE, 2'd2}, 48'd100);
        read_at({ADDR_PADDLE, 2'd2}, 48'd101);
        set_config('1, '1);
        position_event(1'b0, 8'd255, 8'd255);
        read_at({ADDR_TSTART, 4'h8}, '0);
        read_at({ADDR_PADDLE, 2'd0}, 48'd65535);
        read_at({ADDR_PADDLE, 2'd1}, 48'd65536);
        button_event(2'd0, 1'b1);
        button_event(2'd0, 1'b0);
        repeat (3) tick_once();
        read_at(ADDR_BUTTON0, '0);
        set_config(16'd1, 16'd1);
        button_event(2'd2, 1'b1);
        button_event(2'd2, 1'b0);
        tick_once();
        read_at(ADDR_BUTTON2, '0);
        read_at({ADDR_PADDLE, 2'd0}, 48'd1);
        read_at({ADDR_PADDLE, 2'd0}, 48'd2);
    endtask

    task automatic test_random_traffic();
        int                phase;
        int                counted;
        int                pick;
        bit                paused;
        bit                mapped;
        t_item             it;
        logic [HOLD_W-1:0] latch;
        logic [HOLD_W-1:0] span;
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    latch = 16'($urandom_range(1, 12));
                    span  = 16'($urandom);
                end
                1: begin
                    latch = '1;
                    span  = '1;
                end
                2: begin
                    latch = '0;
                    span  = '0;
                end
                3: begin
                    latch = 16'($urandom_range(1, 40));
                    span  = 16'($urandom_range(0, 300));
                end
                default: begin
                    latch = 16'($urandom);
                    span  = 16'($urandom);
                end
            endcase
            set_config(latch, span);
            // one phase runs near the top of the cycle counter so sums wrap
            cycle_cursor = (phase == 1) ? {CYCLE_BITS{1'b1}} - 48'd20000
                                        : CYCLE_BITS'({$urandom, $urandom});
            counted = 0;
            paused  = 1'b0;
            while (counted < 160) begin
                steady = (counted < 30);
                if (counted >= 80 && !paused) begin
                    settle_port();
                    paused = 1'b1;
                end
                it = filler();
                cycle_cursor = cycle_cursor + $urandom_range(1, 400);
                pick = $urandom_range(0, 99);
                if (pick < 18) begin
                    it.kind      = KIND_READ;
                    it.address   = {ADDR_TSTART, 4'($urandom)};
                    it.cycle_now = cycle_cursor;
                end else if (pick < 45) begin
                    it.kind    = KIND_READ;
                    it.address = {ADDR_PADDLE, 2'($urandom)};
                    // mostly right around the end of the timer
                    if ($urandom_range(0, 4) != 0)
                        it.cycle_now = model_tstart + paddle_delay(it.address[1:0])
                                       + $urandom_range(0, 6) - 3;
                    else if ($urandom_range(0, 1) != 0)
                        it.cycle_now = model_tstart + $urandom_range(0, 70000) - 5;
                end else if (pick < 60) begin
                    it.kind    = KIND_READ;
                    it.address = ADDR_BUTTON0 + 8'($urandom_range(0, 2));
                end else if (pick < 72) begin
                    it.kind = KIND_TICK;
                end else if (pick < 85) begin
                    it.kind         = KIND_BUTTON;
                    it.button_index = ($urandom_range(0, 19) == 0) ? 2'd3
                                                                   : 2'($urandom_range(0, 2));
                end else if (pick < 93) begin
                    it.kind = KIND_POSITION;
                    if ($urandom_range(0, 3) == 0) begin
                        it.x_pos = $urandom_range(0, 1) ? '1 : '0;
                        it.y_pos = $urandom_range(0, 1) ? '1 : '0;
                    end
                end
                send_request(it);
                mapped = (it.address >= ADDR_BUTTON0 && it.address <= ADDR_BUTTON2) ||
                         (it.address[7:2] == ADDR_PADDLE) ||
                         (it.address[7:4] == ADDR_TSTART);
                if (!((it.kind == KIND_BUTTON && it.button_index == 2'd3) ||
                      (it.kind == KIND_READ && !mapped)))
                    counted++;
            end
        end
        steady = 1'b0;
    endtask

    initial begin : result_monitor
        int    stall;
        t_bit7 want;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            if (bit7_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual value %0b driven %0b",
                         $time, m_axis_tdata[0], m_axis_tuser);
                fail_count++;
            end else begin
                want = bit7_queue.pop_front();
                if (m_axis_tdata[0] !== want.value) begin
                    $display("%0t: bit_value expected %0b actual %0b",
                             $time, want.value, m_axis_tdata[0]);
                    fail_count++;
                end
                if (m_axis_tuser !== want.driven) begin
                    $display("%0t: bit_driven expected %0b actual %0b",
                             $time, want.driven, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int i;
        model_latch  = LATCH_RESET;
        model_span   = SPAN_RESET;
        model_tstart = '0;
        for (i = 0; i < NUM_BUTTONS; i++) begin
            model_hold[i]  = '0;
            model_level[i] = 1'b0;
        end
        for (i = 0; i < NUM_AXES; i++)
            model_axis[i] = AXIS_CENTER;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_basics();
        test_register_extremes();
        test_random_traffic();
        settle_port();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #6000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
